>>> hw/rtl/sadr_pkg.sv
// shared types and constants of the averaging spi converter reader
// no dependencies; imported by the accumulator, the divider and the top level
`default_nettype none

package sadr_pkg;

	localparam int SUM_W = 20;  // running sum of samples
	localparam int CNT_W = 8;   // frame count and divisor
	localparam int AVG_W = 12;  // averaged result
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	typedef enum logic [1:0] {
		ST_READY,
		ST_ACCUM,
		ST_DIV,
		ST_EMIT
	} sadr_state_t;

	// status of a bit-serial unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/sadr_accum.sv
// bit-serial accumulator holding the running sample sum
// one sum bit per cycle, lsb first; depends on sadr_pkg
`default_nettype none

module sadr_accum #(
	parameter int SMP_W = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       clear,
	input  wire logic                       start,
	input  wire logic [SMP_W-1:0]           sample,
	output logic      [sadr_pkg::SUM_W-1:0] sum,
	output sadr_pkg::unit_sts_t             sts
);
	import sadr_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic [SUM_W-1:0]  sum_q;
	logic [SMP_W-1:0]  add_q;
	logic              carry_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              bit_sum;
	logic              bit_carry;

	assign bit_sum = sum_q[0] ^ add_q[0] ^ carry_q;
	assign bit_carry = (sum_q[0] & add_q[0]) | (sum_q[0] & carry_q) | (add_q[0] & carry_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			add_q <= '0;
			carry_q <= 1'b0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (clear) begin
				sum_q <= '0;
				busy_q <= 1'b0;
			end else if (start) begin
				add_q <= sample;
				carry_q <= 1'b0;
				step_q <= STEP_W'(SUM_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// sum rotates right so it is back in place after SUM_W steps
				sum_q <= {bit_sum, sum_q[SUM_W-1:1]};
				add_q <= {1'b0, add_q[SMP_W-1:1]};
				carry_q <= bit_carry;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	assign sum = sum_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

`default_nettype wire

>>> hw/rtl/sadr_div.sv
// restoring divider producing one quotient bit per cycle
// sum by an 8-bit count; depends on sadr_pkg
`default_nettype none

module sadr_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [sadr_pkg::SUM_W-1:0] dividend,
	input  wire logic [sadr_pkg::CNT_W-1:0] divisor,
	output logic      [sadr_pkg::SUM_W-1:0] quotient,
	output sadr_pkg::unit_sts_t             sts
);
	import sadr_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              fits;
	logic [CNT_W:0]    diff;

	// remainder stays below the divisor, so the shifted trial fits CNT_W+1 bits
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_W'(SUM_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

`default_nettype wire

>>> hw/rtl/spi_adc_averaging_reader.sv
// Averaging reader for a multi-channel spi converter.
// s_* channel: s_tuser is the command (0 start a reading, 1 a received frame),
//   s_tdata carries the three received bytes of a frame.
// m_* channel: exactly one transaction per input transaction; send_frame asks
//   for another 24-bit exchange starting with request_byte, reading_done marks
//   the averaged value.
// cfg_* channel: register writes (0 channel, 1 differential, 2 sample count),
//   always ready; write only while no item is in flight.
// Flow: a start item or a frame while idle passes through the result register
//   and then the output register. A frame of a running reading first goes through
//   the bit-serial accumulator, and the final frame also through the bit-serial
//   divider. One item is worked on at a time; s_tready is high again the cycle the
//   result enters the output register.
// The output register holds its transaction while m_tready is low; the next
//   item is accepted meanwhile and its result waits in the result register.
// Reset clears the registers to channel 0, single-ended, count 1, and leaves
//   the reader idle with an empty output.
`default_nettype none

module spi_adc_averaging_reader #(
	parameter int RESULT_BITS = 12,
	parameter int CHANNEL_SELECT_BITS = 3
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [23:0]                         s_tdata,  // rx_first, rx_second, rx_third
	input  wire logic [0:0]                          s_tuser,  // command
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [23:0]                         m_tdata,  // request_byte, averaged_value, pad
	output logic      [1:0]                          m_tuser,  // send_frame, reading_done
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [sadr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sadr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sadr_pkg::*;

	localparam int CH_W = 3;

	sadr_state_t      state_q, state_d;
	logic [CH_W-1:0]  channel_q;
	logic             diff_q;
	logic [CNT_W-1:0] count_q;
	logic             active_q, active_d;
	logic [CNT_W-1:0] frames_q, frames_d;

	logic             m_tvalid_q;
	logic [7:0]       out_req_q;
	logic             out_send_q;
	logic             out_done_q;
	logic [AVG_W-1:0] out_avg_q;

	logic [7:0]       res_req_q, res_req_d;
	logic             res_send_q, res_send_d;
	logic             res_done_q, res_done_d;
	logic [AVG_W-1:0] res_avg_q, res_avg_d;
	logic             res_load;
	logic             out_load;

	logic             in_acc;
	logic             acc_start;
	logic             acc_clear;
	logic             div_start;
	logic             chan_ok;
	logic [CNT_W-1:0] cnt_eff;
	logic [7:0]       req_byte;
	logic [11:0]      smp_wide;
	logic [RESULT_BITS-1:0] sample;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] quot;
	unit_sts_t        acc_sts;
	unit_sts_t        div_sts;

	assign in_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_READY);
	assign cfg_ready = 1'b1;

	assign chan_ok = (channel_q >> CHANNEL_SELECT_BITS) == '0;
	assign cnt_eff = (count_q == '0) ? CNT_W'(1) : count_q;

	// request byte and sample layout follow the device variant
	generate
		if (CHANNEL_SELECT_BITS == 1) begin : g_one_sel
			assign req_byte = {1'b1, ~diff_q, channel_q[0], 1'b1, 4'b0000};
			if (RESULT_BITS == 10) begin : g_ten
				assign smp_wide = {2'b00, s_tdata[1], 1'b0, s_tdata[15:8]};
			end else begin : g_wide
				assign smp_wide = {s_tdata[1], 1'b0, s_tdata[15:8], s_tdata[23:22]};
			end
			assign sample = smp_wide[RESULT_BITS-1:0];
		end else begin : g_multi_sel
			assign req_byte = {2'b01, ~diff_q, channel_q, 2'b00};
			assign smp_wide = {s_tdata[15:8], s_tdata[23:20]};
			assign sample = smp_wide[11 -: RESULT_BITS];
		end
	endgenerate

	sadr_accum #(
		.SMP_W(RESULT_BITS)
	) u_accum (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (acc_clear),
		.start (acc_start),
		.sample(sample),
		.sum   (sum),
		.sts   (acc_sts)
	);

	sadr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum),
		.divisor (cnt_eff),
		.quotient(quot),
		.sts     (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= '0;
			diff_q <= 1'b0;
			count_q <= CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CHANNEL: channel_q <= cfg_data[CH_W-1:0];
				CFG_DIFF:    diff_q <= cfg_data[0];
				CFG_COUNT:   count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
			active_q <= 1'b0;
			frames_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			active_q <= active_d;
			frames_q <= frames_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_req_q <= res_req_d;
			res_send_q <= res_send_d;
			res_done_q <= res_done_d;
			res_avg_q <= res_avg_d;
		end
		if (out_load) begin
			out_req_q <= res_req_q;
			out_send_q <= res_send_q;
			out_done_q <= res_done_q;
			out_avg_q <= res_avg_q;
		end
	end

	always_comb begin
		state_d = state_q;
		active_d = active_q;
		frames_d = frames_q;
		acc_start = 1'b0;
		acc_clear = 1'b0;
		div_start = 1'b0;
		res_load = 1'b0;
		out_load = 1'b0;
		res_req_d = '0;
		res_send_d = 1'b0;
		res_done_d = 1'b0;
		res_avg_d = '0;
		unique case (state_q)
			ST_READY: begin
				if (in_acc) begin
					if (s_tuser[0] == CMD_START) begin
						acc_clear = 1'b1;
						frames_d = '0;
						res_load = 1'b1;
						state_d = ST_EMIT;
						if (chan_ok) begin
							active_d = 1'b1;
							res_req_d = req_byte;
							res_send_d = 1'b1;
						end else begin
							active_d = 1'b0;
							res_done_d = 1'b1;
						end
					end else if (active_q) begin
						acc_start = 1'b1;
						frames_d = frames_q + 1'b1;
						state_d = ST_ACCUM;
					end else begin
						// frame while idle answers all zero
						res_load = 1'b1;
						state_d = ST_EMIT;
					end
				end
			end
			ST_ACCUM: begin
				if (acc_sts.done) begin
					if (frames_q >= cnt_eff || frames_q == '0) begin
						div_start = 1'b1;
						state_d = ST_DIV;
					end else begin
						res_load = 1'b1;
						res_req_d = req_byte;
						res_send_d = 1'b1;
						state_d = ST_EMIT;
					end
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					res_load = 1'b1;
					res_done_d = 1'b1;
					res_avg_d = quot[AVG_W-1:0];
					active_d = 1'b0;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d = ST_READY;
				end
			end
			default: state_d = ST_READY;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {4'b0000, out_avg_q, out_req_q};
	assign m_tuser = {out_done_q, out_send_q};

endmodule

`default_nettype wire

>>> hw/rtl/sadr_checker.sv
// port-level checks of the averaging reader, bound to the top level
// depends on spi_adc_averaging_reader
`default_nettype none

module sadr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	a_send_or_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("send_frame and reading_done both set");

	a_req_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
		else $error("request byte without send_frame");

	a_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[23:8] == 16'd0)
		else $error("averaged value without reading_done");

endmodule

bind spi_adc_averaging_reader sadr_checker u_sadr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire
